// ----- rtl/core/apce_pkg.sv -----
// Shared types, constants and byte-code functions for the audio processor
// command encoder. No dependencies.
package apce_pkg;

  typedef enum logic [2:0] {
    CMD_VOLUME  = 3'd0,
    CMD_BASS    = 3'd1,
    CMD_TREBLE  = 3'd2,
    CMD_BALANCE = 3'd3,
    CMD_SOURCE  = 3'd4,
    CMD_MUTE    = 3'd5,
    CMD_UNMUTE  = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_SEND
  } state_t;

  localparam int NUM_SRC   = 4;
  localparam int MAX_BYTES = 8;
  localparam int SRC_W     = $clog2(NUM_SRC);
  localparam int IDX_W     = $clog2(MAX_BYTES);
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);

  localparam logic [6:0]        VOL_MAX   = 7'd100;
  localparam logic [6:0]        VOL_RESET = 7'd50;
  localparam logic [1:0]        GAIN_MAX  = 2'd3;
  localparam logic signed [3:0] STEP_MAX  = 4'sd7;
  localparam logic signed [3:0] STEP_MIN  = -4'sd7;

  // 96 and 112 as high nibbles
  localparam logic [3:0] BASS_HI   = 4'h6;
  localparam logic [3:0] TREBLE_HI = 4'h7;
  // 0x80 and 0xA0 as high three bits
  localparam logic [2:0] BAL_L_HI  = 3'b100;
  localparam logic [2:0] BAL_R_HI  = 3'b101;
  localparam logic [7:0] SWITCH_BASE = 8'h40;
  localparam logic [7:0] MUTE_LEAD   = 8'h00;
  localparam logic [7:0] MUTE_ATT    = 8'h3F;

  // v*63/100 as v*330309 >> 19, exact for v in 0..100
  localparam logic [7:0]  VOL_FULL  = 8'd63;
  localparam logic [18:0] VOL_RECIP = 19'd330309;
  localparam int          VOL_SHIFT = 19;

  typedef struct packed {
    logic [6:0]        vol;
    logic signed [3:0] bass;
    logic signed [3:0] treble;
    logic signed [3:0] bal;
  } settings_t;

  localparam settings_t SETTINGS_RESET = '{
    vol: VOL_RESET, bass: 4'sd0, treble: 4'sd0, bal: 4'sd0
  };

  typedef struct packed {
    logic [7:0] cbyte;
    logic       fstart;
    logic       fend;
  } ent_t;

  typedef struct packed {
    logic             load;
    logic             calc;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  function automatic logic [7:0] vol_code(input logic [6:0] v);
    logic [25:0] p;
    p = 26'(v) * 26'(VOL_RECIP);
    return VOL_FULL - 8'(p >> VOL_SHIFT);
  endfunction

  function automatic logic [3:0] tone_nib(input logic signed [3:0] s);
    if (s > 4'sd0) begin
      return 4'd15 - $unsigned(s);
    end else begin
      return 4'd7 + $unsigned(s);
    end
  endfunction

  // m*31/7
  function automatic logic [4:0] bal_att(input logic [2:0] m);
    logic [4:0] r;
    unique case (m)
      3'd0: r = 5'd0;
      3'd1: r = 5'd4;
      3'd2: r = 5'd8;
      3'd3: r = 5'd13;
      3'd4: r = 5'd17;
      3'd5: r = 5'd22;
      3'd6: r = 5'd26;
      3'd7: r = 5'd31;
    endcase
    return r;
  endfunction

  function automatic logic signed [3:0] clamp_step(input logic signed [7:0] s);
    if (s < 8'(STEP_MIN)) begin
      return STEP_MIN;
    end else if (s > 8'(STEP_MAX)) begin
      return STEP_MAX;
    end else begin
      return 4'(s);
    end
  endfunction

endpackage

// ----- rtl/core/apce_dp.sv -----
// Datapath: kept settings, per-source store, byte list builder and output mux.
// Depends on apce_pkg.
module apce_dp
  import apce_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  input  cmd_t                command,
  input  logic [7:0]          volume_level,
  input  logic signed [7:0]   step_level,
  input  logic [7:0]          source_select,
  input  logic [7:0]          source_gain,
  output logic [CNT_W-1:0]    cnt,
  output ent_t                out_ent,
  output logic                is_muted,
  output logic [6:0]          active_volume,
  output logic [SRC_W-1:0]    active_source
);

  cmd_t                cmd_r;
  logic [6:0]          vol_in_r;
  logic signed [3:0]   step_r;
  logic [SRC_W-1:0]    src_r;
  logic [1:0]          gain_r;
  settings_t           ld_r;

  logic [6:0]          cur_vol_r,    cur_vol_nxt;
  logic signed [3:0]   cur_bass_r,   cur_bass_nxt;
  logic signed [3:0]   cur_treble_r, cur_treble_nxt;
  logic signed [3:0]   cur_bal_r,    cur_bal_nxt;
  logic [SRC_W-1:0]    cur_src_r,    cur_src_nxt;
  logic                mute_r,       mute_nxt;

  settings_t           set_mem [NUM_SRC];
  logic [NUM_SRC-1:0]  set_vld_r;

  ent_t                ents_r [MAX_BYTES];
  ent_t                ents_nxt [MAX_BYTES];
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  logic                wr_en;
  logic [SRC_W-1:0]    rd_addr;
  logic [6:0]          new_vol;
  logic [7:0]          vc;
  logic [7:0]          sw_byte;
  logic [7:0]          bal_l_byte;
  logic [7:0]          bal_r_byte;
  logic [3:0]          bal_mag;
  logic signed [3:0]   bal_sel;
  logic signed [3:0]   bass_sel;
  logic signed [3:0]   treble_sel;

  assign rd_addr = (source_select > 8'(NUM_SRC - 1)) ? '0 : source_select[SRC_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= command;
      vol_in_r <= (volume_level > 8'(VOL_MAX)) ? VOL_MAX : volume_level[6:0];
      step_r   <= clamp_step(step_level);
      src_r    <= rd_addr;
      gain_r   <= (source_gain > 8'(GAIN_MAX)) ? GAIN_MAX : source_gain[1:0];
      ld_r     <= set_vld_r[rd_addr] ? set_mem[rd_addr] : SETTINGS_RESET;
    end
  end

  assign new_vol = (cmd_r == CMD_VOLUME) ? vol_in_r :
                   (cmd_r == CMD_SOURCE) ? ld_r.vol : cur_vol_r;
  assign vc      = vol_code(new_vol);
  assign sw_byte = SWITCH_BASE + 8'({~gain_r, 3'b000}) + 8'(src_r);

  assign bal_sel    = (cmd_r == CMD_SOURCE) ? ld_r.bal    : step_r;
  assign bass_sel   = (cmd_r == CMD_SOURCE) ? ld_r.bass   : step_r;
  assign treble_sel = (cmd_r == CMD_SOURCE) ? ld_r.treble : step_r;
  assign bal_mag    = (bal_sel < 4'sd0) ? 4'(-bal_sel) : $unsigned(bal_sel);
  assign bal_l_byte = {BAL_L_HI, (bal_sel > 4'sd0) ? bal_att(bal_mag[2:0]) : 5'd0};
  assign bal_r_byte = {BAL_R_HI, (bal_sel < 4'sd0) ? bal_att(bal_mag[2:0]) : 5'd0};

  always_comb begin
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < MAX_BYTES; i++) begin
      ents_nxt[i] = '0;
    end
    cur_vol_nxt    = cur_vol_r;
    cur_bass_nxt   = cur_bass_r;
    cur_treble_nxt = cur_treble_r;
    cur_bal_nxt    = cur_bal_r;
    cur_src_nxt    = cur_src_r;
    mute_nxt       = mute_r;
    wr_en          = 1'b0;

    unique case (cmd_r)
      CMD_VOLUME: begin
        cur_vol_nxt = new_vol;
        wr_en = 1'b1;
        ents_nxt[n[IDX_W-1:0]] = '{vc, 1'b1, 1'b1}; n = n + 1'b1;
        if (new_vol != 7'd0 && mute_r) begin
          mute_nxt = 1'b0;
          ents_nxt[n[IDX_W-1:0]] = '{MUTE_LEAD, 1'b1, 1'b0}; n = n + 1'b1;
          ents_nxt[n[IDX_W-1:0]] = '{vc, 1'b0, 1'b1}; n = n + 1'b1;
        end
      end
      CMD_BASS: begin
        cur_bass_nxt = step_r;
        wr_en = 1'b1;
        ents_nxt[n[IDX_W-1:0]] = '{{BASS_HI, tone_nib(bass_sel)}, 1'b1, 1'b1};
        n = n + 1'b1;
      end
      CMD_TREBLE: begin
        cur_treble_nxt = step_r;
        wr_en = 1'b1;
        ents_nxt[n[IDX_W-1:0]] = '{{TREBLE_HI, tone_nib(treble_sel)}, 1'b1, 1'b1};
        n = n + 1'b1;
      end
      CMD_BALANCE: begin
        cur_bal_nxt = step_r;
        wr_en = 1'b1;
        ents_nxt[n[IDX_W-1:0]] = '{bal_l_byte, 1'b1, 1'b0}; n = n + 1'b1;
        ents_nxt[n[IDX_W-1:0]] = '{bal_r_byte, 1'b0, 1'b1}; n = n + 1'b1;
      end
      CMD_SOURCE: begin
        cur_src_nxt    = src_r;
        cur_vol_nxt    = ld_r.vol;
        cur_bass_nxt   = ld_r.bass;
        cur_treble_nxt = ld_r.treble;
        cur_bal_nxt    = ld_r.bal;
        ents_nxt[n[IDX_W-1:0]] = '{sw_byte, 1'b1, 1'b1}; n = n + 1'b1;
        ents_nxt[n[IDX_W-1:0]] = '{vc, 1'b1, 1'b1}; n = n + 1'b1;
        if (new_vol != 7'd0 && mute_r) begin
          mute_nxt = 1'b0;
          ents_nxt[n[IDX_W-1:0]] = '{MUTE_LEAD, 1'b1, 1'b0}; n = n + 1'b1;
          ents_nxt[n[IDX_W-1:0]] = '{vc, 1'b0, 1'b1}; n = n + 1'b1;
        end
        ents_nxt[n[IDX_W-1:0]] = '{{BASS_HI, tone_nib(bass_sel)}, 1'b1, 1'b1};
        n = n + 1'b1;
        ents_nxt[n[IDX_W-1:0]] = '{{TREBLE_HI, tone_nib(treble_sel)}, 1'b1, 1'b1};
        n = n + 1'b1;
        ents_nxt[n[IDX_W-1:0]] = '{bal_l_byte, 1'b1, 1'b0}; n = n + 1'b1;
        ents_nxt[n[IDX_W-1:0]] = '{bal_r_byte, 1'b0, 1'b1}; n = n + 1'b1;
      end
      CMD_MUTE: begin
        if (!mute_r) begin
          mute_nxt = 1'b1;
          ents_nxt[n[IDX_W-1:0]] = '{MUTE_LEAD, 1'b1, 1'b0}; n = n + 1'b1;
          ents_nxt[n[IDX_W-1:0]] = '{MUTE_ATT, 1'b0, 1'b1}; n = n + 1'b1;
        end
      end
      CMD_UNMUTE: begin
        if (mute_r) begin
          mute_nxt = 1'b0;
          ents_nxt[n[IDX_W-1:0]] = '{MUTE_LEAD, 1'b1, 1'b0}; n = n + 1'b1;
          ents_nxt[n[IDX_W-1:0]] = '{vc, 1'b0, 1'b1}; n = n + 1'b1;
        end
      end
      default: begin
      end
    endcase
    cnt_nxt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vol_r    <= VOL_RESET;
      cur_bass_r   <= 4'sd0;
      cur_treble_r <= 4'sd0;
      cur_bal_r    <= 4'sd0;
      cur_src_r    <= '0;
      mute_r       <= 1'b0;
      cnt_r        <= '0;
      set_vld_r    <= '0;
    end else if (cmd.calc) begin
      cur_vol_r    <= cur_vol_nxt;
      cur_bass_r   <= cur_bass_nxt;
      cur_treble_r <= cur_treble_nxt;
      cur_bal_r    <= cur_bal_nxt;
      cur_src_r    <= cur_src_nxt;
      mute_r       <= mute_nxt;
      cnt_r        <= cnt_nxt;
      if (wr_en) begin
        set_vld_r[cur_src_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      for (int i = 0; i < MAX_BYTES; i++) begin
        ents_r[i] <= ents_nxt[i];
      end
      if (wr_en) begin
        set_mem[cur_src_r] <= '{vol: cur_vol_nxt, bass: cur_bass_nxt,
                                treble: cur_treble_nxt, bal: cur_bal_nxt};
      end
    end
  end

  assign cnt           = cnt_r;
  assign out_ent       = ents_r[cmd.idx];
  assign is_muted      = mute_r;
  assign active_volume = cur_vol_r;
  assign active_source = cur_src_r;

endmodule

// ----- rtl/core/apce_ctrl.sv -----
// Controller: accept, compute and send sequencing with the byte index.
// Depends on apce_pkg.
module apce_ctrl
  import apce_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic             out_tlast,
  input  logic [CNT_W-1:0] cnt,
  output dp_cmd_t          dp_cmd
);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             is_last;

  assign is_last = ((CNT_W'(idx_r) + 1'b1) == cnt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    in_tready   = 1'b0;
    out_tvalid  = 1'b0;
    out_tlast   = 1'b0;
    dp_cmd.load = 1'b0;
    dp_cmd.calc = 1'b0;
    dp_cmd.idx  = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          dp_cmd.load = 1'b1;
          state_nxt   = ST_CALC;
        end
      end
      ST_CALC: begin
        dp_cmd.calc = 1'b1;
        idx_nxt     = '0;
        state_nxt   = ST_SEND;
      end
      ST_SEND: begin
        if (cnt == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          out_tvalid = 1'b1;
          out_tlast  = is_last;
          if (out_tready) begin
            if (is_last) begin
              idx_nxt   = '0;
              state_nxt = ST_IDLE;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/audio_processor_command_encoder.sv -----
// Audio processor command encoder, top level.
// Depends on apce_pkg, apce_ctrl and apce_dp.
//
// Usage:
// The input channel takes one audio-control command per transaction: the
// command code in in_tuser, the volume, step, source and gain operands in
// in_tdata. The block updates its settings, mute flag and per-source store
// and then sends the resulting processor bytes on the output channel, one
// byte per transaction, with frame start/end in out_tuser and out_tlast on
// the final byte of the command. Every output transaction also carries the
// mute flag, volume and source as they stand after the whole command.
// Timing: a command is accepted in ST_IDLE and its byte list is computed in
// ST_CALC, then one byte per cycle goes out while out_tready is high; a
// command gives up to 8 bytes, or none. The next command is accepted only
// after the last byte has gone.
// Reset: volume 50, tone and balance 0, source 0, unmuted, all four source
// entries back to defaults; no transaction is pending.
// Stall: with out_tready low the current byte and its flags hold steady.
module audio_processor_command_encoder
  import apce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // volume_level, step_level, source_select, source_gain
  input  logic [2:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // command_byte, is_muted, active_volume, active_source
  output logic [1:0]  out_tuser,  // frame_start, frame_end
  output logic        out_tlast
);

  dp_cmd_t          dp_cmd;
  logic [CNT_W-1:0] cnt;
  ent_t             out_ent;
  logic             is_muted;
  logic [6:0]       active_volume;
  logic [SRC_W-1:0] active_source;

  apce_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .cnt        (cnt),
    .dp_cmd     (dp_cmd)
  );

  apce_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (dp_cmd),
    .command       (cmd_t'(in_tuser)),
    .volume_level  (in_tdata[7:0]),
    .step_level    (signed'(in_tdata[15:8])),
    .source_select (in_tdata[23:16]),
    .source_gain   (in_tdata[31:24]),
    .cnt           (cnt),
    .out_ent       (out_ent),
    .is_muted      (is_muted),
    .active_volume (active_volume),
    .active_source (active_source)
  );

  assign out_tdata = {6'd0, active_source, active_volume, is_muted, out_ent.cbyte};
  assign out_tuser = {out_ent.fend, out_ent.fstart};

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input accepted while bytes are still being sent");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("byte run ended without a last byte");

  a_vol_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:9] <= VOL_MAX)
    else $error("active volume above limit");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt <= CNT_W'(MAX_BYTES))
    else $error("byte count above limit");
`endif

endmodule

// ----- verif/audio_processor_command_encoder_tb.sv -----
`timescale 1ns / 100ps
// Testbench for audio_processor_command_encoder: directed and random audio commands,
// with every output byte checked against a behavioural encoder model kept here.
// Depends on apce_pkg and the encoder RTL.
module audio_processor_command_encoder_tb
  import apce_pkg::*;
();

  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 16;
  localparam int ITEMS_PER_PHASE = 115;

  typedef struct {
    logic [2:0]        cmd;
    logic [7:0]        vol;
    logic signed [7:0] step;
    logic [7:0]        src;
    logic [7:0]        gain;
  } audio_cmd_t;

  typedef struct packed {
    logic [7:0] cbyte;
    logic       fstart;
    logic       fend;
    logic       is_last;
    logic       muted;
    logic [6:0] vol;
    logic [1:0] src;
  } proc_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // volume_level, step_level, source_select, source_gain
  logic [2:0]  in_tuser = '0;   // command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // command_byte, is_muted, active_volume, active_source
  logic [1:0]  out_tuser;       // frame_start, frame_end
  logic        out_tlast;

  audio_processor_command_encoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // model state
  logic [6:0]        m_vol;
  logic signed [3:0] m_bass;
  logic signed [3:0] m_treble;
  logic signed [3:0] m_bal;
  logic [1:0]        m_src;
  logic              m_muted;
  settings_t         m_store [NUM_SRC];

  audio_cmd_t  cmd_queue [$];
  audio_cmd_t  cur_cmd;
  proc_byte_t  byte_burst [$];
  proc_byte_t  exp_bytes [$];
  proc_byte_t  got, want;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int cmds_accepted = 0;
  int bytes_checked = 0;
  int full_reloads = 0;
  int quiet_cycles = 0;

  function automatic logic [7:0] att_code(input int v);
    return 8'(63 - (v * 63) / 100);
  endfunction

  function automatic logic signed [3:0] sat_step(input int s);
    if (s < -7) return -4'sd7;
    if (s > 7) return 4'sd7;
    return 4'(s);
  endfunction

  function automatic logic [7:0] tone_byte(input logic signed [3:0] s, input int base);
    int t;
    t = (int'(s) > 0) ? 15 - int'(s) : 7 + int'(s);
    return 8'(base + t);
  endfunction

  function void push_byte(input logic [7:0] b, input logic fs, input logic fe);
    proc_byte_t p;
    p = '0;
    p.cbyte = b;
    p.fstart = fs;
    p.fend = fe;
    byte_burst.push_back(p);
  endfunction

  function void save_settings();
    m_store[m_src] = '{vol: m_vol, bass: m_bass, treble: m_treble, bal: m_bal};
  endfunction

  function void apply_unmute();
    if (m_muted) begin
      m_muted = 1'b0;
      push_byte(MUTE_LEAD, 1'b1, 1'b0);
      push_byte(att_code(int'(m_vol)), 1'b0, 1'b1);
    end
  endfunction

  function void apply_volume(input int v);
    if (v > 100) v = 100;
    m_vol = 7'(v);
    push_byte(att_code(v), 1'b1, 1'b1);
    if (v > 0) apply_unmute();
    save_settings();
  endfunction

  function void apply_bass(input int s);
    m_bass = sat_step(s);
    push_byte(tone_byte(m_bass, 96), 1'b1, 1'b1);
    save_settings();
  endfunction

  function void apply_treble(input int s);
    m_treble = sat_step(s);
    push_byte(tone_byte(m_treble, 112), 1'b1, 1'b1);
    save_settings();
  endfunction

  function void apply_balance(input int s);
    int l, r;
    m_bal = sat_step(s);
    l = (int'(m_bal) > 0) ? (int'(m_bal) * 31) / 7 : 0;
    r = (int'(m_bal) < 0) ? (-int'(m_bal) * 31) / 7 : 0;
    push_byte(8'h80 | 8'(l), 1'b1, 1'b0);
    push_byte(8'hA0 | 8'(r), 1'b0, 1'b1);
    save_settings();
  endfunction

  function void apply_source(input int s, input int g);
    settings_t ld;
    if (s > 3) s = 0;
    if (g > 3) g = 3;
    save_settings();
    m_src = 2'(s);
    ld = m_store[s];
    push_byte(8'(8'h40 + ((3 - g) << 3) + s), 1'b1, 1'b1);
    apply_volume(int'(ld.vol));
    apply_bass(int'(ld.bass));
    apply_treble(int'(ld.treble));
    apply_balance(int'(ld.bal));
  endfunction

  function void encode_command(input audio_cmd_t c);
    byte_burst.delete();
    case (c.cmd)
      CMD_VOLUME:  apply_volume(int'(c.vol));
      CMD_BASS:    apply_bass(int'(c.step));
      CMD_TREBLE:  apply_treble(int'(c.step));
      CMD_BALANCE: apply_balance(int'(c.step));
      CMD_SOURCE:  apply_source(int'(c.src), int'(c.gain));
      CMD_MUTE: begin
        if (!m_muted) begin
          m_muted = 1'b1;
          push_byte(MUTE_LEAD, 1'b1, 1'b0);
          push_byte(MUTE_ATT, 1'b0, 1'b1);
        end
      end
      CMD_UNMUTE:  apply_unmute();
      default: ;
    endcase
    if (byte_burst.size() == MAX_BYTES) full_reloads++;
    foreach (byte_burst[k]) begin
      byte_burst[k].is_last = (k == byte_burst.size() - 1);
      byte_burst[k].muted = m_muted;
      byte_burst[k].vol = m_vol;
      byte_burst[k].src = m_src;
      exp_bytes.push_back(byte_burst[k]);
    end
  endfunction

  function void log_mismatch(input string what, input proc_byte_t e, input proc_byte_t a);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: exp byte %h fs %b fe %b last %b mute %b vol %0d src %0d",
               $realtime, what, e.cbyte, e.fstart, e.fend, e.is_last, e.muted, e.vol, e.src);
      $display("    got byte %h fs %b fe %b last %b mute %b vol %0d src %0d",
               a.cbyte, a.fstart, a.fend, a.is_last, a.muted, a.vol, a.src);
    end
  endfunction

  function void add_cmd(input logic [2:0] cmd, input logic [7:0] vol, input int step,
                        input logic [7:0] src, input logic [7:0] gain);
    audio_cmd_t c;
    c.cmd = cmd;
    c.vol = vol;
    c.step = 8'(step);
    c.src = src;
    c.gain = gain;
    cmd_queue.push_back(c);
  endfunction

  function void add_random_cmd();
    audio_cmd_t c;
    c.cmd = ($urandom_range(0, 99) < 3) ? CMD_UNUSED : 3'($urandom_range(0, 6));
    case ($urandom_range(0, 3))
      0:       c.vol = 8'd0;
      1:       c.vol = 8'($urandom);
      default: c.vol = 8'($urandom_range(0, 120));
    endcase
    c.step = ($urandom_range(0, 9) < 6) ? 8'(int'($urandom_range(0, 18)) - 9) : 8'($urandom);
    c.src = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    c.gain = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 4)) : 8'($urandom);
    cmd_queue.push_back(c);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        encode_command(cur_cmd);
        cmds_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_cmd = cmd_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= cur_cmd.cmd;
          in_tdata <= {cur_cmd.gain, cur_cmd.src, cur_cmd.step, cur_cmd.vol};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.cbyte = out_tdata[7:0];
        got.muted = out_tdata[8];
        got.vol = out_tdata[15:9];
        got.src = out_tdata[17:16];
        got.fstart = out_tuser[0];
        got.fend = out_tuser[1];
        got.is_last = out_tlast;
        bytes_checked++;
        if (exp_bytes.size() == 0) begin
          log_mismatch("unexpected byte", '0, got);
        end else begin
          want = exp_bytes.pop_front();
          if (got !== want) log_mismatch("byte mismatch", want, got);
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d bytes outstanding", exp_bytes.size());
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int stall_tab [4];
    int idle_tab [4];
    idle_tab = '{0, 64, 0, 37};
    stall_tab = '{0, 0, 64, 37};
    m_vol = VOL_RESET;
    m_bass = '0;
    m_treble = '0;
    m_bal = '0;
    m_src = '0;
    m_muted = 1'b0;
    foreach (m_store[i]) m_store[i] = SETTINGS_RESET;

    // directed: field extremes, every command, mute corner cases
    add_cmd(CMD_VOLUME, 8'd0, 0, 8'd0, 8'd0);
    add_cmd(CMD_VOLUME, 8'd255, 0, 8'd0, 8'd0);
    add_cmd(CMD_VOLUME, 8'd100, 0, 8'd0, 8'd0);
    add_cmd(CMD_BASS, 8'd0, -128, 8'd0, 8'd0);
    add_cmd(CMD_BASS, 8'd0, 127, 8'd0, 8'd0);
    add_cmd(CMD_TREBLE, 8'd0, -7, 8'd0, 8'd0);
    add_cmd(CMD_TREBLE, 8'd0, 1, 8'd0, 8'd0);
    add_cmd(CMD_BALANCE, 8'd0, 7, 8'd0, 8'd0);
    add_cmd(CMD_BALANCE, 8'd0, -8, 8'd0, 8'd0);
    add_cmd(CMD_MUTE, 8'd0, 0, 8'd0, 8'd0);
    add_cmd(CMD_MUTE, 8'd0, 0, 8'd0, 8'd0);
    add_cmd(CMD_VOLUME, 8'd0, 0, 8'd0, 8'd0);      // stays muted
    add_cmd(CMD_VOLUME, 8'd37, 0, 8'd0, 8'd0);     // unmutes
    add_cmd(CMD_UNMUTE, 8'd0, 0, 8'd0, 8'd0);      // already unmuted
    add_cmd(CMD_MUTE, 8'd0, 0, 8'd0, 8'd0);
    add_cmd(CMD_SOURCE, 8'd0, 0, 8'd3, 8'd0);      // reload while muted, full burst
    add_cmd(CMD_BALANCE, 8'd0, 0, 8'd0, 8'd0);
    add_cmd(CMD_SOURCE, 8'd0, 0, 8'd255, 8'd255);  // out of range source and gain
    add_cmd(CMD_MUTE, 8'd0, 0, 8'd0, 8'd0);
    add_cmd(CMD_UNMUTE, 8'd0, 0, 8'd0, 8'd0);
    add_cmd(CMD_SOURCE, 8'd0, 0, 8'd3, 8'd1);
    add_cmd(CMD_UNUSED, 8'hFF, -1, 8'hFF, 8'hFF);
    add_cmd(CMD_SOURCE, 8'd0, 0, 8'd2, 8'd2);
    add_cmd(CMD_TREBLE, 8'd0, 0, 8'd0, 8'd0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      repeat (ITEMS_PER_PHASE) add_random_cmd();
      while (cmd_queue.size() > 0 || in_tvalid || exp_bytes.size() > 0) @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d commands across four handshake pressure phases; %0d bytes compared",
             cmds_accepted, bytes_checked);
    $display("including %0d eight-byte source reloads with unmute", full_reloads);
    if (mismatches == 0 && exp_bytes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
